>>> hw/rtl/lbvs_pkg.sv
// Package for the linear blend vertex skinning block.
// Holds the item codes and fixed arithmetic widths; it depends on nothing.
`default_nettype none
package lbvs_pkg;
	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_SKIN  = 1'b1
	} action_t;

	localparam int ELEMS   = 12;
	localparam int ROWS    = 3;
	localparam int VAL_W   = 32;
	localparam int WGT_W   = 16;
	localparam int CNT_W   = 9;
	localparam int PROD_W  = 64;
	localparam int T_W     = 50;
	localparam int SPLIT   = 24;
	localparam int PHI_W   = T_W - SPLIT + WGT_W + 1;
	localparam int PLO_W   = SPLIT + WGT_W;
	localparam int FULL_W  = T_W + WGT_W + 1;
	localparam int CON_W   = FULL_W - 15;
	localparam int ACC_W   = CON_W + 2;

	typedef logic signed [VAL_W-1:0] val_t;
endpackage
`default_nettype wire

>>> hw/rtl/linear_blend_vertex_skinning_top.sv
// One request per cycle while the result is not held. The pipeline is RAM read, 36 matrix
// products, row sums, weight products, scaling, and accumulate with saturation
// or passthrough if unused; the whole pipeline stalls together when the result is held.
// Reset clears the valid bits and the joint count; the matrix storage is not cleared.
// Depends on lbvs_pkg and lbvs_ram.
`default_nettype none
module linear_blend_vertex_skinning_top #(
	parameter int JOINTS     = 64,
	parameter int INFLUENCES = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lbvs_pkg::CNT_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       action,
	input  wire logic [7:0]                 matrix_joint,
	input  wire logic [3:0]                 matrix_element,
	input  wire logic signed [31:0]         matrix_value,
	input  wire logic signed [31:0]         pos_x,
	input  wire logic signed [31:0]         pos_y,
	input  wire logic signed [31:0]         pos_z,
	input  wire logic [31:0]                joint_set,
	input  wire logic [63:0]                weight_set,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [31:0]              out_x,
	output logic signed [31:0]              out_y,
	output logic signed [31:0]              out_z,
	output logic                            passed_through
);
	import lbvs_pkg::*;

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(JOINTS);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd2147483648);

	logic [CNT_W-1:0] joint_count_q;
	logic [CNT_W-1:0] count_eff;
	logic adv, wr_en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	val_t pos_s1 [ROWS];
	val_t pos_s2 [ROWS];
	val_t pos_s3 [ROWS];
	val_t pos_s4 [ROWS];
	val_t pos_s5 [ROWS];
	logic [WGT_W-1:0] w_s1 [INFLUENCES];
	logic [WGT_W-1:0] w_s2 [INFLUENCES];
	logic [WGT_W-1:0] w_s3 [INFLUENCES];
	logic [INFLUENCES-1:0] use_s1, use_s2, use_s3, use_s4;
	logic used_s5;
	logic [VAL_W-1:0] m_s1 [INFLUENCES][ELEMS];
	logic signed [PROD_W-1:0] prod_s2 [INFLUENCES][ROWS][ROWS];
	logic signed [VAL_W-1:0] trans_s2 [INFLUENCES][ROWS];
	logic signed [T_W-1:0] t_s3 [INFLUENCES][ROWS];
	logic signed [PHI_W-1:0] phi_s4 [INFLUENCES][ROWS];
	logic [PLO_W-1:0] plo_s4 [INFLUENCES][ROWS];
	logic signed [CON_W-1:0] con_s5 [INFLUENCES][ROWS];
	logic signed [ACC_W-1:0] acc [ROWS];
	logic signed [VAL_W-1:0] res [ROWS];

	assign cfg_ready = 1'b1;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign count_eff = (joint_count_q > CNT_MAX) ? CNT_MAX : joint_count_q;
	assign wr_en = in_valid && adv && (action == ACT_WRITE)
		&& (CNT_W'(matrix_joint) < CNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			joint_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && (action == ACT_SKIN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	for (genvar i = 0; i < INFLUENCES; i++) begin : g_inf
		for (genvar e = 0; e < ELEMS; e++) begin : g_elem
			lbvs_ram #(
				.WIDTH(VAL_W),
				.DEPTH(JOINTS)
			) u_ram (
				.clk  (clk),
				.we   (wr_en && (matrix_element == 4'(e))),
				.waddr(matrix_joint[JW-1:0]),
				.wdata(matrix_value),
				.re   (adv),
				.raddr(joint_set[8*i +: JW]),
				.rdata(m_s1[i][e])
			);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				w_s1[i] <= weight_set[WGT_W*i +: WGT_W];
				use_s1[i] <= (weight_set[WGT_W*i +: WGT_W] != '0)
					&& (CNT_W'(joint_set[8*i +: 8]) < count_eff);
				w_s2[i] <= w_s1[i];
				w_s3[i] <= w_s2[i];
				for (int r = 0; r < ROWS; r++) begin
					for (int c = 0; c < ROWS; c++) begin
						prod_s2[i][r][c] <= $signed(m_s1[i][c*ROWS + r]) * pos_s1[c];
					end
					trans_s2[i][r] <= $signed(m_s1[i][9 + r]);
					t_s3[i][r] <= T_W'((prod_s2[i][r][0] >>> 16) + (prod_s2[i][r][1] >>> 16)
						+ (prod_s2[i][r][2] >>> 16) + PROD_W'(trans_s2[i][r]));
					phi_s4[i][r] <= $signed(t_s3[i][r][T_W-1:SPLIT]) * $signed({1'b0, w_s3[i]});
					plo_s4[i][r] <= t_s3[i][r][SPLIT-1:0] * w_s3[i];
					con_s5[i][r] <= use_s4[i]
						? CON_W'(((FULL_W'(phi_s4[i][r]) <<< SPLIT)
							+ $signed(FULL_W'(plo_s4[i][r]))) >>> 15)
						: '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			pos_s2 <= pos_s1;
			pos_s3 <= pos_s2;
			pos_s4 <= pos_s3;
			pos_s5 <= pos_s4;
			use_s2 <= use_s1;
			use_s3 <= use_s2;
			use_s4 <= use_s3;
			used_s5 <= |use_s4;
			out_x <= res[0];
			out_y <= res[1];
			out_z <= res[2];
			passed_through <= !used_s5;
		end
	end

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			acc[r] = '0;
			for (int i = 0; i < INFLUENCES; i++) begin
				acc[r] = acc[r] + ACC_W'(con_s5[i][r]);
			end
			if (!used_s5) begin
				res[r] = pos_s5[r];
			end else if (acc[r] > SAT_HI) begin
				res[r] = SAT_HI[VAL_W-1:0];
			end else if (acc[r] < SAT_LO) begin
				res[r] = SAT_LO[VAL_W-1:0];
			end else begin
				res[r] = acc[r][VAL_W-1:0];
			end
		end
	end

	a_skin_only: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) && v_s1 |-> $past(in_valid && (action == ACT_SKIN)))
		else $error("Stage one holds a request that was not a skin request.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s5) && $stable(v_s1))
		else $error("Pipeline moved while the result was stalled.");
endmodule
`default_nettype wire

>>> hw/rtl/lbvs_ram.sv
// Generic single write port, single read port RAM with registered read.
// Used for the skin matrix storage; no dependencies.
`default_nettype none
module lbvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire
